// ===== rtl/spcg_pkg.sv =====
// Shared types and constants for the SplitMix64 / PCG random generator.
// Used by spcg_ctrl, spcg_dp and the top level; depends on nothing.
package spcg_pkg;

    localparam logic [63:0] LCG_MUL    = 64'd6364136223846793005;
    localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_M1     = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_M2     = 64'h94D049BB133111EB;

    localparam int MIX_SH1   = 30;
    localparam int MIX_SH2   = 27;
    localparam int MIX_SH3   = 31;
    localparam int ROT_LSB   = 59;
    localparam int XS_SH1    = 18;
    localparam int XS_SH2    = 27;
    localparam int FRAC_SH   = 11;

    // multiply unit: three 32x32 partial products, result on count 3
    localparam logic [1:0] MUL_LAST = 2'd3;
    // divide unit: a load, 64 restoring steps, result on count 65
    localparam logic [6:0] DIV_LAST = 7'd65;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM = 8'd1;

    typedef enum logic [1:0] {
        OP_RESEED = 2'd0,
        OP_RAW    = 2'd1,
        OP_BOUND  = 2'd2,
        OP_FRAC   = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RS_LOAD,
        S_MIX_ADV,
        S_MUL1,
        S_MUL2,
        S_MIX_FIN,
        S_LCG_MUL,
        S_COMBINE,
        S_LIM_DIV,
        S_CHECK,
        S_REM_DIV,
        S_RESULT
    } t_state;

    typedef enum logic [3:0] {
        U_NOP,
        U_ACCEPT,
        U_RS_LOAD,
        U_MIX_ADV,
        U_MUL1,
        U_MUL2,
        U_FIN_RS,
        U_FIN_DR,
        U_LCG_MUL,
        U_COMBINE,
        U_DIV_LIM,
        U_DIV_REM,
        U_RES_ZERO,
        U_RES_DRAW,
        U_RES_FRAC,
        U_RES_REM
    } t_uop;

    typedef struct packed {
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic draw_lt;
        logic n_zero;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/spcg_ctrl.sv =====
// Sequencer for the random generator: walks each operation through the datapath.
// Depends on spcg_pkg; drives spcg_dp through t_cmd and reads t_status.
module spcg_ctrl
    import spcg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [1:0]  i_in_opcode,
    input  t_status     i_status,
    output logic        o_in_ready,
    output t_cmd        o_cmd
);

    t_state  r_state, n_state;
    t_opcode r_op,    n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_RESEED;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = t_opcode'(i_in_opcode);
                    unique case (t_opcode'(i_in_opcode))
                        OP_RESEED: n_state = S_RS_LOAD;
                        OP_BOUND:  n_state = S_LIM_DIV;
                        OP_RAW,
                        OP_FRAC:   n_state = S_MIX_ADV;
                    endcase
                end
            end
            S_RS_LOAD: n_state = S_MUL1;
            S_MIX_ADV: n_state = S_MUL1;
            S_MUL1:    if (i_status.mul_done) n_state = S_MUL2;
            S_MUL2:    if (i_status.mul_done) n_state = S_MIX_FIN;
            S_MIX_FIN: n_state = S_LCG_MUL;
            S_LCG_MUL: begin
                if (i_status.mul_done) begin
                    n_state = (r_op == OP_RESEED) ? S_RESULT : S_COMBINE;
                end
            end
            S_COMBINE: n_state = (r_op == OP_BOUND) ? S_CHECK : S_RESULT;
            S_LIM_DIV: begin
                if (i_status.n_zero) begin
                    n_state = S_RESULT;
                end else if (i_status.div_done) begin
                    n_state = S_MIX_ADV;
                end
            end
            S_CHECK:   n_state = i_status.draw_lt ? S_REM_DIV : S_MIX_ADV;
            S_REM_DIV: if (i_status.div_done) n_state = S_RESULT;
            S_RESULT:  if (i_status.out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.uop  = U_NOP;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.uop = U_ACCEPT;
            end
            S_RS_LOAD: o_cmd.uop = U_RS_LOAD;
            S_MIX_ADV: o_cmd.uop = U_MIX_ADV;
            S_MUL1:    o_cmd.uop = U_MUL1;
            S_MUL2:    o_cmd.uop = U_MUL2;
            S_MIX_FIN: o_cmd.uop = (r_op == OP_RESEED) ? U_FIN_RS : U_FIN_DR;
            S_LCG_MUL: o_cmd.uop = U_LCG_MUL;
            S_COMBINE: o_cmd.uop = U_COMBINE;
            S_LIM_DIV: if (!i_status.n_zero) o_cmd.uop = U_DIV_LIM;
            S_CHECK:   o_cmd.uop = U_NOP;
            S_REM_DIV: o_cmd.uop = U_DIV_REM;
            S_RESULT: begin
                if (i_status.out_free) begin
                    unique case (r_op)
                        OP_RESEED: o_cmd.uop = U_RES_ZERO;
                        OP_RAW:    o_cmd.uop = U_RES_DRAW;
                        OP_FRAC:   o_cmd.uop = U_RES_FRAC;
                        OP_BOUND:  o_cmd.uop = i_status.n_zero ? U_RES_ZERO : U_RES_REM;
                    endcase
                end
            end
            default: o_cmd.uop = U_NOP;
        endcase
    end

endmodule

// ===== rtl/spcg_dp.sv =====
// Datapath of the random generator: state registers, shared multiply and divide units,
// output register. Depends on spcg_pkg; commanded by spcg_ctrl.
module spcg_dp
    import spcg_pkg::*;
#(
    parameter int BOUND_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [31:0]          i_bound,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [63:0]          o_out_value,
    output t_status              o_status
);

    logic [63:0] r_seed;
    logic [62:0] r_stream;
    logic [63:0] r_mix, r_lcg, r_inc;
    logic [63:0] r_z, r_draw, r_lim;
    logic [BOUND_BITS-1:0] r_n;

    logic [1:0]  r_mcnt;
    logic [63:0] r_pp, r_acc;
    logic [6:0]  r_dcnt;
    logic [63:0] r_dq;
    logic [BOUND_BITS-1:0] r_rem;

    logic        r_ovalid;
    logic [63:0] r_value;

    logic        w_is_mul, w_is_div, w_is_res;
    logic [63:0] w_ma, w_mb, w_mres, w_prod;
    logic [31:0] w_pa, w_pb;
    logic [BOUND_BITS:0]   w_t, w_nx;
    logic [BOUND_BITS-1:0] w_rem_nx;
    logic [63:0] w_fin, w_xs, w_rot;
    logic [4:0]  w_r;
    logic [5:0]  w_lsh;
    logic        w_out_free;

    assign w_is_mul = (i_cmd.uop == U_MUL1) || (i_cmd.uop == U_MUL2)
                   || (i_cmd.uop == U_LCG_MUL);
    assign w_is_div = (i_cmd.uop == U_DIV_LIM) || (i_cmd.uop == U_DIV_REM);
    assign w_is_res = (i_cmd.uop == U_RES_ZERO) || (i_cmd.uop == U_RES_DRAW)
                   || (i_cmd.uop == U_RES_FRAC) || (i_cmd.uop == U_RES_REM);

    // multiply operands
    always_comb begin
        unique case (i_cmd.uop)
            U_MUL1: begin
                w_ma = r_z ^ (r_z >> MIX_SH1);
                w_mb = MIX_M1;
            end
            U_MUL2: begin
                w_ma = r_z ^ (r_z >> MIX_SH2);
                w_mb = MIX_M2;
            end
            default: begin
                w_ma = r_lcg;
                w_mb = LCG_MUL;
            end
        endcase
    end

    always_comb begin
        unique case (r_mcnt)
            2'd0: begin
                w_pa = w_ma[31:0];
                w_pb = w_mb[31:0];
            end
            2'd1: begin
                w_pa = w_ma[31:0];
                w_pb = w_mb[63:32];
            end
            default: begin
                w_pa = w_ma[63:32];
                w_pb = w_mb[31:0];
            end
        endcase
    end

    assign w_prod = {32'd0, w_pa} * {32'd0, w_pb};
    assign w_mres = {r_acc[63:32] + r_pp[31:0], r_acc[31:0]};

    // restoring divide step
    assign w_t  = {r_rem, r_dq[63]};
    assign w_nx = {1'b0, r_n};
    always_comb begin
        if (w_t >= w_nx) begin
            w_rem_nx = BOUND_BITS'(w_t - w_nx);
        end else begin
            w_rem_nx = w_t[BOUND_BITS-1:0];
        end
    end

    // output function
    assign w_fin = r_z ^ (r_z >> MIX_SH3);
    assign w_r   = r_lcg[63:ROT_LSB];
    assign w_xs  = (r_lcg ^ (r_lcg >> XS_SH1)) >> XS_SH2;
    assign w_lsh = 6'(7'd64 - {2'd0, w_r});
    assign w_rot = (w_xs >> w_r) | (w_xs << w_lsh);

    assign w_out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= '0;
            r_stream <= '0;
            r_mix    <= '0;
            r_lcg    <= '0;
            r_inc    <= '0;
            r_mcnt   <= '0;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_SEED)   r_seed   <= i_cfg_data;
                if (i_cfg_index == CFG_STREAM) r_stream <= i_cfg_data[62:0];
            end

            if (w_is_mul) begin
                r_mcnt <= (r_mcnt == MUL_LAST) ? 2'd0 : r_mcnt + 2'd1;
            end
            if (w_is_div) begin
                r_dcnt <= (r_dcnt == DIV_LAST) ? 7'd0 : r_dcnt + 7'd1;
            end

            unique case (i_cmd.uop)
                U_RS_LOAD: begin
                    r_inc <= {r_stream, 1'b1};
                    r_mix <= r_seed;
                end
                U_MIX_ADV: r_mix <= r_mix + MIX_GOLDEN;
                U_FIN_RS:  r_lcg <= w_fin + r_inc;
                U_LCG_MUL: if (r_mcnt == MUL_LAST) r_lcg <= w_mres + r_inc;
                default: ;
            endcase

            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            if (w_is_res) r_ovalid <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pp <= w_prod;
        unique case (r_mcnt)
            2'd1:    r_acc <= r_pp;
            2'd2:    r_acc <= {r_acc[63:32] + r_pp[31:0], r_acc[31:0]};
            default: r_acc <= r_acc;
        endcase

        if (w_is_div) begin
            if (r_dcnt == 7'd0) begin
                r_dq  <= (i_cmd.uop == U_DIV_LIM) ? '1 : r_draw;
                r_rem <= '0;
            end else if (r_dcnt != DIV_LAST) begin
                r_dq  <= {r_dq[62:0], 1'b0};
                r_rem <= w_rem_nx;
            end
        end

        unique case (i_cmd.uop)
            U_ACCEPT:  r_n <= BOUND_BITS'(i_bound);
            U_RS_LOAD: r_z <= (r_seed ^ MIX_GOLDEN) + MIX_GOLDEN;
            U_MIX_ADV: r_z <= r_mix + MIX_GOLDEN;
            U_MUL1,
            U_MUL2:    if (r_mcnt == MUL_LAST) r_z <= w_mres;
            U_FIN_DR:  r_z <= w_fin;
            U_COMBINE: r_draw <= w_rot ^ r_z;
            U_DIV_LIM: if (r_dcnt == DIV_LAST) r_lim <= ~64'd0 - 64'(r_rem);
            U_RES_ZERO: r_value <= '0;
            U_RES_DRAW: r_value <= r_draw;
            U_RES_FRAC: r_value <= r_draw >> FRAC_SH;
            U_RES_REM:  r_value <= 64'(r_rem);
            default: ;
        endcase
    end

    assign o_status.mul_done = (r_mcnt == MUL_LAST);
    assign o_status.div_done = (r_dcnt == DIV_LAST);
    assign o_status.draw_lt  = (r_draw < r_lim);
    assign o_status.n_zero   = (r_n == '0);
    assign o_status.out_free = w_out_free;

    assign o_out_valid = r_ovalid;
    assign o_out_value = r_value;

    a_mul_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcnt != 2'd0 |-> w_is_mul)
        else $error("multiply count running without a multiply command");

    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcnt != 7'd0 |-> w_is_div)
        else $error("divide count running without a divide command");

    a_inc_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inc != 64'd0 |-> r_inc[0])
        else $error("LCG increment lost its low bit");

    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_is_res |-> w_out_free)
        else $error("result written over a beat not yet taken");

endmodule

// ===== rtl/splitmix_pcg_random_generator.sv =====
// Each draw runs three 64-bit multiplies on one shared 32x32 multiplier. A bounded index
// adds two bit-serial remainder passes (limit, then draw mod n) and draws again on each
// rejected draw. One item at a time; the sequencer returns to idle between items, and a new
// item is taken while the last result beat waits at the output. Reset (synchronous, active
// low) clears seed, stream, generator state and output valid.
module splitmix_pcg_random_generator
    import spcg_pkg::*;
#(
    parameter int BOUND_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // input beats
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,   // [1:0] opcode, [33:2] bound, [39:34] zero

    // result beats
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // [63:0] value

    // configuration writes: index 0 seed, index 1 stream_select
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // registers take every write at once
    assign o_cfg_ready = 1'b1;

    // sequencer: accepts a beat in idle, then steps the datapath
    spcg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_opcode (s_axis_tdata[1:0]),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (w_cmd)
    );

    // datapath: state, multiply and divide units, output register
    spcg_dp #(
        .BOUND_BITS (BOUND_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_bound     (s_axis_tdata[33:2]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_value (m_axis_tdata),
        .o_status    (w_status)
    );

endmodule

// ===== bench/spcg_checker.sv =====
// Checker for the SplitMix64 / PCG random generator: watches the config, input and
// result channels, predicts each result value and compares. Depends on spcg_pkg.
`timescale 1ns / 100ps
module spcg_checker
    import spcg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [63:0]          m_axis_tdata,
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_results_seen
);

    logic [63:0] seed_reg, stream_reg;
    logic [63:0] mix_st, lcg_st, lcg_inc;
    logic [63:0] value_q[$];

    function automatic logic [63:0] mix_out(input logic [63:0] s);
        logic [63:0] z;
        z = s;
        z = (z ^ (z >> 30)) * MIX_M1;
        z = (z ^ (z >> 27)) * MIX_M2;
        return z ^ (z >> 31);
    endfunction

    // advance both generators and return the combined draw
    function automatic logic [63:0] next_draw();
        logic [63:0] pre, x, xs;
        int unsigned r;
        mix_st = mix_st + MIX_GOLDEN;
        pre = mix_out(mix_st);
        lcg_st = lcg_st * LCG_MUL + lcg_inc;
        x = lcg_st;
        r = x[63:59];
        xs = (x ^ (x >> 18)) >> 27;
        return ((xs >> r) | (xs << ((64 - r) & 63))) ^ pre;
    endfunction

    function automatic logic [63:0] predict_value(input t_opcode op, input logic [31:0] n);
        logic [63:0] d, lim;
        case (op)
            OP_RESEED: begin
                lcg_inc = {stream_reg[62:0], 1'b1};
                mix_st = seed_reg;
                lcg_st = mix_out((seed_reg ^ MIX_GOLDEN) + MIX_GOLDEN) + lcg_inc;
                lcg_st = lcg_st * LCG_MUL + lcg_inc;
                return 64'd0;
            end
            OP_RAW: return next_draw();
            OP_BOUND: begin
                if (n == 0) return 64'd0;
                lim = (64'hFFFF_FFFF_FFFF_FFFF / {32'd0, n}) * {32'd0, n};
                do d = next_draw(); while (d >= lim);
                return d % {32'd0, n};
            end
            default: return next_draw() >> 11;
        endcase
    endfunction

    always @(posedge i_clk) begin
        logic [63:0] exp_v;
        if (!i_rst_n) begin
            seed_reg <= '0; stream_reg <= '0;
            mix_st = '0; lcg_st = '0; lcg_inc = '0;
            value_q.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_SEED) seed_reg <= i_cfg_data;
                else if (i_cfg_index == CFG_STREAM) stream_reg <= {1'b0, i_cfg_data[62:0]};
            end
            if (s_axis_tvalid && s_axis_tready)
                value_q.push_back(predict_value(t_opcode'(s_axis_tdata[1:0]),
                                                s_axis_tdata[33:2]));
            if (m_axis_tvalid && m_axis_tready) begin
                o_results_seen <= o_results_seen + 1;
                if (value_q.size() == 0) begin
                    $error("value: unexpected beat, actual %h", m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_v = value_q.pop_front();
                    if (exp_v !== m_axis_tdata) begin
                        $error("value: expected %h actual %h", exp_v, m_axis_tdata);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = value_q.size();
    end

endmodule

// ===== bench/tb_splitmix_pcg_random_generator.sv =====
// Testbench top for splitmix_pcg_random_generator: drives config writes and input
// beats with random idling; checking lives in spcg_checker. Depends on spcg_pkg.
`timescale 1ns / 100ps
module tb_splitmix_pcg_random_generator;
    import spcg_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [39:0]          s_axis_tdata = '0;   // [1:0] opcode, [33:2] bound, [39:34] zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;        // [63:0] value
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data = '0;

    int fail_count, pending, results_seen;
    int send_idle_pct, recv_idle_pct;
    bit hold_off;
    bit stim_done;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    splitmix_pcg_random_generator uut (.*);

    spcg_checker chk (
        .*,
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results_seen(results_seen)
    );

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // drive one config write, wait for it to land, then drop valid before returning
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one input beat, idling first at the current rate; valid stays up after
    // the accept so that beats can follow with no gap
    task automatic send_item(input t_opcode op, input logic [31:0] n);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, n, op};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // drop valid, wait until all results drained, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // bounds: often small, sometimes full-width random, near the maximum or powers of two
    function automatic logic [31:0] pick_bound();
        case ($urandom_range(5))
            0: return $urandom_range(16);
            1: return $urandom;
            2: return 32'd1 << $urandom_range(31);
            3: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom_range(1000, 1);
        endcase
    endfunction

    task automatic random_phase(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(49) == 0) send_item(OP_RESEED, $urandom);
            else send_item(t_opcode'($urandom_range(3, 1)), pick_bound());
        end
    endtask

    initial begin
        int k;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // draws from the all-zero state before any reseed
        send_item(OP_RAW, 32'd0);
        send_item(OP_FRAC, 32'd0);
        send_item(OP_BOUND, 32'd7);
        drain();

        // extremes of both registers, every operation, bound edge cases
        write_reg(CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_STREAM, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(OP_RESEED, 32'd0);
        send_item(OP_RAW, 32'hFFFF_FFFF);
        send_item(OP_FRAC, 32'd0);
        send_item(OP_BOUND, 32'd0);
        send_item(OP_BOUND, 32'd1);
        send_item(OP_BOUND, 32'hFFFF_FFFF);
        send_item(OP_BOUND, 32'h8000_0001);
        send_item(OP_BOUND, 32'h5555_5555);
        send_item(OP_BOUND, 32'hAAAA_AAAA);
        drain();
        write_reg(CFG_SEED, 64'd0);
        write_reg(CFG_STREAM, 64'hFFFF_FFFF_FFFF_FFFF);   // top bit dropped by the block
        send_item(OP_RESEED, 32'd0);
        send_item(OP_RAW, 32'd0);
        send_item(OP_BOUND, 32'd2);
        send_item(OP_FRAC, 32'd0);
        drain();

        // sender idles lightly, receiver heavily
        send_idle_pct = 16; recv_idle_pct = 74;
        write_reg(CFG_SEED, {$urandom, $urandom});
        write_reg(CFG_STREAM, {$urandom, $urandom});
        send_item(OP_RESEED, 32'd0);
        random_phase(500);
        drain();

        // pressure: receiver holds off while the sender keeps offering
        hold_off = 1'b1;
        fork
            begin repeat (3000) @(posedge i_clk); hold_off = 1'b0; end
            for (k = 0; k < 30; k++) send_item(OP_RAW, 32'd0);
        join
        drain();

        // the other way round
        send_idle_pct = 74; recv_idle_pct = 16;
        write_reg(CFG_SEED, 64'd1);
        write_reg(CFG_STREAM, 64'd0);
        send_item(OP_RESEED, 32'd0);
        random_phase(480);
        drain();

        // no idling on either side
        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(CFG_SEED, {$urandom, $urandom});
        write_reg(CFG_STREAM, {$urandom, $urandom});
        send_item(OP_RESEED, 32'd0);
        random_phase(500);
        drain();

        $display("Covered all four operations over %0d result beats, with zero, full-range",
                 results_seen);
        $display("and random seeds/streams, bound edge cases, idling and a long output stall.");
        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    // worst case: about 1530 items, many of them bounded draws, under heavy stalls
    initial begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/spcg_pkg.sv
rtl/spcg_ctrl.sv
rtl/spcg_dp.sv
rtl/splitmix_pcg_random_generator.sv
bench/spcg_checker.sv
bench/tb_splitmix_pcg_random_generator.sv
